FILE: design/msp_pkg.sv
// shared constants and types for the motor speed pid controller
// no dependencies
`default_nettype none

package msp_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 8;

  // accumulator width holds +/- 255 with GAIN_FRAC_BITS fraction bits
  localparam int ACC_W     = GAIN_FRAC_BITS + 10;
  localparam int OUT_LIMIT = 255 << GAIN_FRAC_BITS;
  localparam int ROUND_ADD = (1 << GAIN_FRAC_BITS) - 1;

  localparam int ERR_W  = 17;
  localparam int DERR_W = 18;
  localparam int PROD_W = 34;
  localparam int SUM_W  = 36;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PID_ENABLE  = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_ERROR_LIMIT = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: design/motor_speed_pid_controller.sv
// top level of the motor speed pid controller: five-register pipeline
// depends on msp_pkg
`default_nettype none

// Takes one encoder sample and target per transaction and returns one result per transaction.
// A new transaction is accepted every cycle unless m_axis_tready holds the output; a result passes
// through the input register, error stage, multiplier stage, integral stage and output register.
// Speed and error state close in the error stage and the integral closes in the integral stage,
// so consecutive samples need no gap.
// Configuration writes are taken at any time, cfg_ready is always high; write them while idle.
module motor_speed_pid_controller
  import msp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [31:0]            s_axis_tdata,   // encoder_count, target_speed
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [31:0]                 m_axis_tdata    // dir_a, dir_b, duty, measured_speed
);

  logic                     pid_enable;
  logic signed [15:0]       gain_p;
  logic signed [15:0]       gain_i;
  logic signed [15:0]       gain_d;
  logic [14:0]              error_limit;

  logic [COUNT_BITS-1:0]    last_count;
  logic signed [ERR_W-1:0]  prior_error;
  logic signed [ACC_W-1:0]  integral_sum;

  // input register
  logic                     v_in;
  logic [15:0]              in_count;
  logic signed [15:0]       in_target;

  // error stage
  logic                     v_s2;
  logic                     s2_en;
  logic signed [15:0]       s2_speed;
  logic signed [15:0]       s2_target;
  logic signed [ERR_W-1:0]  s2_err;
  logic signed [DERR_W-1:0] s2_derr;

  // multiplier stage
  logic                     v_s3;
  logic                     s3_en;
  logic signed [15:0]       s3_speed;
  logic signed [15:0]       s3_target;
  logic signed [PROD_W-1:0] s3_p;
  logic signed [PROD_W-1:0] s3_i;
  logic signed [PROD_W-1:0] s3_d;

  // integral stage
  logic                     v_s4;
  logic                     s4_en;
  logic signed [15:0]       s4_speed;
  logic signed [15:0]       s4_target;
  logic signed [SUM_W-1:0]  s4_pd;
  logic signed [ACC_W-1:0]  s4_integral;

  // output register
  logic                     v_out;
  logic                     out_dir_a;
  logic                     out_dir_b;
  logic [7:0]               out_duty;
  logic signed [15:0]       out_speed;

  logic can_in, can_s2, can_s3, can_s4, can_out;

  assign can_out       = !v_out || m_axis_tready;
  assign can_s4        = !v_s4 || can_out;
  assign can_s3        = !v_s3 || can_s4;
  assign can_s2        = !v_s2 || can_s3;
  assign can_in        = !v_in || can_s2;
  assign s_axis_tready = can_in;
  assign cfg_ready     = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pid_enable  <= 1'b0;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      error_limit <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PID_ENABLE:  pid_enable  <= cfg_data[0];
        REG_GAIN_P:      gain_p      <= signed'(cfg_data);
        REG_GAIN_I:      gain_i      <= signed'(cfg_data);
        REG_GAIN_D:      gain_d      <= signed'(cfg_data);
        REG_ERROR_LIMIT: error_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // error stage logic
  logic [COUNT_BITS-1:0]    count_c;
  logic [COUNT_BITS-1:0]    count_diff;
  logic signed [15:0]       speed_c;
  logic signed [17:0]       err_raw;
  logic signed [17:0]       err_lim;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [DERR_W-1:0] derr_c;

  always_comb begin
    count_c    = COUNT_BITS'(in_count);
    count_diff = count_c - last_count;
    speed_c    = 16'(signed'(count_diff));
    err_raw    = 18'(speed_c) - 18'(in_target);
    err_lim    = signed'({3'b000, error_limit});
    if (err_raw > err_lim) begin
      err_c = ERR_W'(err_lim);
    end else if (err_raw < -err_lim) begin
      err_c = ERR_W'(-err_lim);
    end else begin
      err_c = ERR_W'(err_raw);
    end
    derr_c = DERR_W'(err_c) - DERR_W'(prior_error);
  end

  // integral stage logic
  logic signed [SUM_W-1:0] integ_raw;
  logic signed [ACC_W-1:0] integ_c;

  always_comb begin
    integ_raw = SUM_W'(integral_sum) + SUM_W'(s3_i);
    if (integ_raw > SUM_W'(OUT_LIMIT)) begin
      integ_c = ACC_W'(OUT_LIMIT);
    end else if (integ_raw < -SUM_W'(OUT_LIMIT)) begin
      integ_c = ACC_W'(-OUT_LIMIT);
    end else begin
      integ_c = ACC_W'(integ_raw);
    end
  end

  // output logic
  logic signed [SUM_W-1:0]   sum_raw;
  logic signed [ACC_W:0]     sum_sat;
  logic signed [ACC_W:0]     drive_pid;
  logic signed [ACC_W:0]     mag_pid;
  logic signed [16:0]        mag_open;
  logic                      neg_c;
  logic [7:0]                duty_c;

  always_comb begin
    sum_raw = s4_pd + SUM_W'(s4_integral);
    if (sum_raw > SUM_W'(OUT_LIMIT)) begin
      sum_sat = (ACC_W+1)'(OUT_LIMIT);
    end else if (sum_raw < -SUM_W'(OUT_LIMIT)) begin
      sum_sat = (ACC_W+1)'(-OUT_LIMIT);
    end else begin
      sum_sat = (ACC_W+1)'(sum_raw);
    end
    // truncate toward zero
    if (sum_sat < 0) begin
      drive_pid = (sum_sat + (ACC_W+1)'(ROUND_ADD)) >>> GAIN_FRAC_BITS;
    end else begin
      drive_pid = sum_sat >>> GAIN_FRAC_BITS;
    end
    mag_pid  = (drive_pid < 0) ? -drive_pid : drive_pid;
    mag_open = (s4_target < 0) ? -17'(s4_target) : 17'(s4_target);
    if (s4_en) begin
      neg_c  = drive_pid < 0;
      duty_c = mag_pid[7:0];
    end else begin
      neg_c  = s4_target < 0;
      duty_c = (mag_open > 17'sd255) ? 8'hff : mag_open[7:0];
    end
  end

  // valid bits and state
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in         <= 1'b0;
      v_s2         <= 1'b0;
      v_s3         <= 1'b0;
      v_s4         <= 1'b0;
      v_out        <= 1'b0;
      last_count   <= '0;
      prior_error  <= '0;
      integral_sum <= '0;
    end else begin
      if (can_in)  v_in  <= s_axis_tvalid;
      if (can_s2)  v_s2  <= v_in;
      if (can_s3)  v_s3  <= v_s2;
      if (can_s4)  v_s4  <= v_s3;
      if (can_out) v_out <= v_s4;
      if (can_s2 && v_in) begin
        last_count <= count_c;
        if (pid_enable) begin
          prior_error <= err_c;
        end
      end
      if (can_s4 && v_s3 && s3_en) begin
        integral_sum <= integ_c;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_in && s_axis_tvalid) begin
      in_count  <= s_axis_tdata[15:0];
      in_target <= signed'(s_axis_tdata[31:16]);
    end
    if (can_s2 && v_in) begin
      s2_en     <= pid_enable;
      s2_speed  <= speed_c;
      s2_target <= in_target;
      s2_err    <= err_c;
      s2_derr   <= derr_c;
    end
    if (can_s3 && v_s2) begin
      s3_en     <= s2_en;
      s3_speed  <= s2_speed;
      s3_target <= s2_target;
      s3_p      <= PROD_W'(gain_p) * PROD_W'(s2_err);
      s3_i      <= PROD_W'(gain_i) * PROD_W'(s2_err);
      s3_d      <= PROD_W'(gain_d) * PROD_W'(s2_derr);
    end
    if (can_s4 && v_s3) begin
      s4_en       <= s3_en;
      s4_speed    <= s3_speed;
      s4_target   <= s3_target;
      s4_pd       <= SUM_W'(s3_p) + SUM_W'(s3_d);
      s4_integral <= integ_c;
    end
    if (can_out && v_s4) begin
      out_dir_a <= neg_c;
      out_dir_b <= !neg_c;
      out_duty  <= duty_c;
      out_speed <= s4_speed;
    end
  end

  assign m_axis_tvalid = v_out;
  assign m_axis_tdata  = {6'b000000, out_speed, out_duty, out_dir_b, out_dir_a};

  a_dir_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] ^ m_axis_tdata[1]))
    else $error("direction bits not complementary");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[9:2] != 8'd0))
    else $error("negative drive with zero duty");

  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= ACC_W'(OUT_LIMIT)) && (integral_sum >= ACC_W'(-OUT_LIMIT)))
    else $error("integral out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(can_s2 && v_in) |=> $stable(last_count) && $stable(prior_error))
    else $error("speed state changed without a transaction");

endmodule

`default_nettype wire
